[hdl/rpwc_pkg.sv]
// Shared types, register indexes and reset values of the pulse width capture block.
`timescale 1ns / 1ps
package rpwc_pkg;

	localparam int NUM_CH     = 4;
	localparam int BIT_SEL_W  = 3;
	localparam int PORT_W     = 8;
	localparam int TIME_W     = 32;
	localparam int WIDTH_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 72;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROLL_BIT     = 3'd0,
		REG_PITCH_BIT    = 3'd1,
		REG_THROTTLE_BIT = 3'd2,
		REG_YAW_BIT      = 3'd3,
		REG_MIN_WIDTH    = 3'd4,
		REG_MAX_WIDTH    = 3'd5
	} reg_idx_t;

	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 16'd1000;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 16'd2000;

	typedef logic [BIT_SEL_W-1:0] bit_sel_t;

	typedef struct packed {
		bit_sel_t [NUM_CH-1:0] chan_bit;
		logic [WIDTH_W-1:0]    min_width;
		logic [WIDTH_W-1:0]    max_width;
	} cfg_t;

endpackage

[hdl/rpwc_cfg_regs.sv]
// Configuration register file: channel bit selects and width clamp limits.
`timescale 1ns / 1ps
module rpwc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rpwc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rpwc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rpwc_pkg::cfg_t                   cfg
);
	import rpwc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				cfg_q.chan_bit[c] <= BIT_SEL_W'(c);
			end
			cfg_q.min_width <= MIN_WIDTH_RST;
			cfg_q.max_width <= MAX_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROLL_BIT:     cfg_q.chan_bit[0] <= cfg_data[BIT_SEL_W-1:0];
				REG_PITCH_BIT:    cfg_q.chan_bit[1] <= cfg_data[BIT_SEL_W-1:0];
				REG_THROTTLE_BIT: cfg_q.chan_bit[2] <= cfg_data[BIT_SEL_W-1:0];
				REG_YAW_BIT:      cfg_q.chan_bit[3] <= cfg_data[BIT_SEL_W-1:0];
				REG_MIN_WIDTH:    cfg_q.min_width   <= cfg_data[WIDTH_W-1:0];
				REG_MAX_WIDTH:    cfg_q.max_width   <= cfg_data[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/rpwc_channel.sv]
// One capture channel: edge tracking, start timestamp, clamped width and update flag.
`timescale 1ns / 1ps
module rpwc_channel (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [rpwc_pkg::PORT_W-1:0]    port_bits,
	input  logic [rpwc_pkg::TIME_W-1:0]    now_us,
	input  rpwc_pkg::bit_sel_t             bit_sel,
	input  logic [rpwc_pkg::WIDTH_W-1:0]   min_width,
	input  logic [rpwc_pkg::WIDTH_W-1:0]   max_width,
	output logic [rpwc_pkg::WIDTH_W-1:0]   width,
	output logic                           updated
);
	import rpwc_pkg::*;

	logic               high_q;
	logic [TIME_W-1:0]  start_q;
	logic [WIDTH_W-1:0] width_q;
	logic               upd_q;

	logic               level;
	logic [TIME_W-1:0]  diff;
	logic               upper_zero;
	logic               below_min;
	logic               above_max;
	logic [WIDTH_W-1:0] clamped;

	assign level      = port_bits[bit_sel];
	assign diff       = now_us - start_q;
	assign upper_zero = (diff[TIME_W-1:WIDTH_W] == '0);
	// negative differences count as below the lower limit
	assign below_min  = diff[TIME_W-1] | (upper_zero & (diff[WIDTH_W-1:0] < min_width));
	assign above_max  = below_min ? (min_width > max_width)
	                              : (!upper_zero | (diff[WIDTH_W-1:0] > max_width));
	assign clamped    = above_max ? max_width : (below_min ? min_width : diff[WIDTH_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q  <= 1'b0;
			start_q <= '0;
			width_q <= '0;
			upd_q   <= 1'b0;
		end else if (en) begin
			upd_q <= 1'b0;
			if (level) begin
				if (!high_q) begin
					start_q <= now_us;
					high_q  <= 1'b1;
				end
			end else if (high_q) begin
				width_q <= clamped;
				high_q  <= 1'b0;
				upd_q   <= 1'b1;
			end
		end
	end

	assign width   = width_q;
	assign updated = upd_q;

endmodule

[hdl/rc_pulse_width_capture.sv]
// Top level of the four-channel RC pulse width capture block.
`timescale 1ns / 1ps
// Takes one item per clock unless a result is stalled: each item is a pin
// sample with its microsecond timestamp, and each yields one result carrying
// the four held pulse widths and a per-channel flag for widths finished by
// that item. An item passes an input register and then the channel result
// registers, where its result shows; while the result is not taken, one more
// item waits in the input register before s_tready drops. Configuration
// writes take effect for items entering the channel stage after the write.
module rc_pulse_width_capture (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rpwc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rpwc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// port_bits[7:0], now_us[39:8]
	input  logic [rpwc_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// roll_width[15:0], pitch_width[31:16], throttle_width[47:32],
	// yaw_width[63:48], updated[67:64], zero[71:68]
	output logic [rpwc_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import rpwc_pkg::*;

	cfg_t cfg;

	logic              valid_s1;
	logic [PORT_W-1:0] port_s1;
	logic [TIME_W-1:0] now_s1;
	logic              out_valid_q;
	logic              advance;
	logic              ch_en;

	logic [NUM_CH-1:0][WIDTH_W-1:0] width;
	logic [NUM_CH-1:0]              updated;

	rpwc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign ch_en    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			port_s1 <= s_tdata[PORT_W-1:0];
			now_s1  <= s_tdata[PORT_W +: TIME_W];
		end
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		rpwc_channel u_ch (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (ch_en),
			.port_bits (port_s1),
			.now_us    (now_s1),
			.bit_sel   (cfg.chan_bit[c]),
			.min_width (cfg.min_width),
			.max_width (cfg.max_width),
			.width     (width[c]),
			.updated   (updated[c])
		);
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - NUM_CH*WIDTH_W - NUM_CH){1'b0}}, updated, width};

endmodule

[hdl/rpwc_checker.sv]
// Port-level checks of the pulse width capture block and their bind.
`timescale 1ns / 1ps
module rpwc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [rpwc_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import rpwc_pkg::*;

	localparam int UPD_LSB = NUM_CH * WIDTH_W;

	logic                           out_hs;
	logic [NUM_CH-1:0]              prev_upd_q;
	logic [NUM_CH*WIDTH_W-1:0]      prev_width_q;
	logic [NUM_CH-1:0]              cur_upd;
	logic [NUM_CH*WIDTH_W-1:0]      cur_width;
	logic [NUM_CH*WIDTH_W-1:0]      upd_mask;

	assign out_hs    = m_tvalid && m_tready;
	assign cur_upd   = m_tdata[UPD_LSB +: NUM_CH];
	assign cur_width = m_tdata[UPD_LSB-1:0];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			upd_mask[c*WIDTH_W +: WIDTH_W] = {WIDTH_W{cur_upd[c]}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_upd_q   <= '0;
			prev_width_q <= '0;
		end else if (out_hs) begin
			prev_upd_q   <= cur_upd;
			prev_width_q <= cur_width;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a pending result");

	a_no_double_update: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs |-> (cur_upd & prev_upd_q) == '0)
		else $error("channel finished a width in two consecutive items");

	a_width_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs |-> ((cur_width ^ prev_width_q) & ~upd_mask) == '0)
		else $error("width changed without its update flag");

endmodule

bind rc_pulse_width_capture rpwc_checker u_rpwc_checker (.*);

[tb/sv/rc_pulse_width_capture_tb.sv]
// Self-checking testbench of the four-channel RC pulse width capture block.
`timescale 1ns / 1ps
module rc_pulse_width_capture_tb;
	import rpwc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;
	localparam int  HOLD_AT_ITEM = 150;
	localparam int  HOLD_CYCLES  = 80;
	localparam int  PHASE_ITEMS  = 110;
	localparam real LIMIT_NS     = 500000.0;

	// updated, then widths packed as {yaw, throttle, pitch, roll}
	typedef struct packed {
		logic [NUM_CH-1:0]           updated;
		logic [NUM_CH*WIDTH_W-1:0]   widths;
	} pulse_report_t;

	typedef struct packed {
		logic [PORT_W-1:0] pins;
		logic [TIME_W-1:0] stamp;
		logic              typed;
		pulse_report_t     report;
	} sample_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	rc_pulse_width_capture u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// shadow of the registers and channel state
	cfg_t               shadow_cfg;
	logic               chan_armed [NUM_CH];
	logic [TIME_W-1:0]  rise_stamp [NUM_CH];
	logic [WIDTH_W-1:0] held_us    [NUM_CH];

	pulse_report_t      pending_q[$];
	int                 mismatches;
	bit                 sender_burst;
	logic [PORT_W-1:0]  pin_levels;
	logic [TIME_W-1:0]  stamp_us;
	string              chan_name [NUM_CH] = '{"roll_width", "pitch_width",
		"throttle_width", "yaw_width"};

	// widths as {yaw, throttle, pitch, roll}
	sample_row_t directed_rows [17] = '{
		'{8'h00, 32'd0,          1'b1, '{4'h0, 64'h0000_0000_0000_0000}},
		'{8'h0F, 32'd100,        1'b1, '{4'h0, 64'h0000_0000_0000_0000}},
		'{8'h00, 32'd1600,       1'b1, '{4'hF, 64'h05DC_05DC_05DC_05DC}},
		'{8'h01, 32'hFFFF_FFF0,  1'b0, '{4'h0, 64'h0}},
		'{8'h00, 32'h0000_0010,  1'b1, '{4'h1, 64'h05DC_05DC_05DC_03E8}},
		'{8'h02, 32'd5000,       1'b0, '{4'h0, 64'h0}},
		'{8'h00, 32'd4000,       1'b1, '{4'h2, 64'h05DC_05DC_03E8_03E8}},
		'{8'h04, 32'd0,          1'b0, '{4'h0, 64'h0}},
		'{8'h00, 32'h8000_0000,  1'b1, '{4'h4, 64'h05DC_03E8_03E8_03E8}},
		'{8'h08, 32'd10,         1'b0, '{4'h0, 64'h0}},
		'{8'h00, 32'h8000_0009,  1'b1, '{4'h8, 64'h07D0_03E8_03E8_03E8}},
		'{8'hF0, 32'd7,          1'b1, '{4'h0, 64'h07D0_03E8_03E8_03E8}},
		'{8'hFF, 32'hFFFF_FFFF,  1'b0, '{4'h0, 64'h0}},
		'{8'hFF, 32'd0,          1'b0, '{4'h0, 64'h0}},
		'{8'h00, 32'd1999,       1'b1, '{4'hF, 64'h07D0_07D0_07D0_07D0}},
		'{8'h05, 32'd3000,       1'b0, '{4'h0, 64'h0}},
		'{8'h00, 32'd3999,       1'b1, '{4'h5, 64'h07D0_03E8_07D0_03E8}}
	};

	always #1 clk = ~clk;

	function automatic logic [WIDTH_W-1:0] clamp_pulse(input logic [TIME_W-1:0] diff);
		longint w;
		w = longint'($signed(diff));
		if (w < longint'(shadow_cfg.min_width))
			w = longint'(shadow_cfg.min_width);
		if (w > longint'(shadow_cfg.max_width))
			w = longint'(shadow_cfg.max_width);
		return w[WIDTH_W-1:0];
	endfunction

	function automatic pulse_report_t capture_sample(input logic [PORT_W-1:0] pins,
			input logic [TIME_W-1:0] now_us);
		pulse_report_t r;
		logic          level;
		r = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			level = pins[shadow_cfg.chan_bit[c]];
			if (level) begin
				if (!chan_armed[c]) begin
					rise_stamp[c] = now_us;
					chan_armed[c] = 1'b1;
				end
			end else if (chan_armed[c]) begin
				held_us[c]    = clamp_pulse(now_us - rise_stamp[c]);
				chan_armed[c] = 1'b0;
				r.updated[c]  = 1'b1;
			end
		end
		for (int c = 0; c < NUM_CH; c++)
			r.widths[c*WIDTH_W +: WIDTH_W] = held_us[c];
		return r;
	endfunction

	task automatic check_report(input pulse_report_t got);
		pulse_report_t want;
		if (pending_q.size() == 0) begin
			$error("unexpected result %h", got);
			mismatches++;
			return;
		end
		want = pending_q.pop_front();
		for (int c = 0; c < NUM_CH; c++) begin
			if (got.widths[c*WIDTH_W +: WIDTH_W] !== want.widths[c*WIDTH_W +: WIDTH_W]) begin
				$error("%s expected %0d got %0d", chan_name[c],
					want.widths[c*WIDTH_W +: WIDTH_W], got.widths[c*WIDTH_W +: WIDTH_W]);
				mismatches++;
			end
		end
		if (got.updated !== want.updated) begin
			$error("updated expected %b got %b", want.updated, got.updated);
			mismatches++;
		end
	endtask

	task automatic offer_sample(input logic [PORT_W-1:0] pins, input logic [TIME_W-1:0] now_us,
			input logic typed, input pulse_report_t typed_report);
		pulse_report_t calc;
		int            gap;
		gap = sender_burst ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {now_us, pins};
		do @(posedge clk); while (!s_tready);
		calc = capture_sample(pins, now_us);
		pending_q.push_back(typed ? typed_report : calc);
		if ($urandom_range(0, 39) == 0)
			sender_burst = !sender_burst;
	endtask

	// drain all pending results, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_ROLL_BIT:     shadow_cfg.chan_bit[0] = data[BIT_SEL_W-1:0];
			REG_PITCH_BIT:    shadow_cfg.chan_bit[1] = data[BIT_SEL_W-1:0];
			REG_THROTTLE_BIT: shadow_cfg.chan_bit[2] = data[BIT_SEL_W-1:0];
			REG_YAW_BIT:      shadow_cfg.chan_bit[3] = data[BIT_SEL_W-1:0];
			REG_MIN_WIDTH:    shadow_cfg.min_width   = data;
			REG_MAX_WIDTH:    shadow_cfg.max_width   = data;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input bit_sel_t r, input bit_sel_t p, input bit_sel_t t,
			input bit_sel_t y, input logic [WIDTH_W-1:0] lo, input logic [WIDTH_W-1:0] hi,
			input bit spare);
		// upper bits of a bit select carry noise
		write_reg(REG_ROLL_BIT,     CFG_DATA_W'(($urandom & 16'hFFF8) | r));
		write_reg(REG_PITCH_BIT,    CFG_DATA_W'(($urandom & 16'hFFF8) | p));
		write_reg(REG_THROTTLE_BIT, CFG_DATA_W'(($urandom & 16'hFFF8) | t));
		write_reg(REG_YAW_BIT,      CFG_DATA_W'(($urandom & 16'hFFF8) | y));
		write_reg(REG_MIN_WIDTH, lo);
		write_reg(REG_MAX_WIDTH, hi);
		if (spare) begin
			write_reg(SPARE_IDX_LO, CFG_DATA_W'($urandom));
			write_reg(SPARE_IDX_HI, CFG_DATA_W'($urandom));
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_pulses(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 19);
			if (pick < 15) begin
				stamp_us += $urandom_range(0, 900);
				for (int b = 0; b < PORT_W; b++)
					if ($urandom_range(0, 3) == 0)
						pin_levels[b] = ~pin_levels[b];
			end else if (pick < 17) begin
				stamp_us   = $urandom;
				pin_levels = PORT_W'($urandom);
			end else if (pick < 19) begin
				// jump near half the timestamp range
				stamp_us   += 32'h7FFF_0000 + $urandom_range(0, 32'h0002_0000);
				pin_levels ^= 8'($urandom);
			end else begin
				pin_levels = PORT_W'($urandom);
			end
			offer_sample(pin_levels, stamp_us, 1'b0, '0);
		end
	endtask

	initial begin : result_sink
		int hold;
		int taken;
		bit burst;
		taken = 0;
		burst = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = burst ? 0 : $urandom_range(0, 4);
			if (taken == HOLD_AT_ITEM)
				hold = HOLD_CYCLES;
			repeat (hold) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_report(m_tdata[NUM_CH*WIDTH_W+NUM_CH-1:0]);
			taken++;
			if ($urandom_range(0, 39) == 0)
				burst = !burst;
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("rc_pulse_width_capture_tb NOT OK");
		$finish;
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		mismatches = 0;
		sender_burst = 1'b0;
		pin_levels = '0;
		stamp_us   = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			shadow_cfg.chan_bit[c] = bit_sel_t'(c);
			chan_armed[c] = 1'b0;
			rise_stamp[c] = '0;
			held_us[c]    = '0;
		end
		shadow_cfg.min_width = MIN_WIDTH_RST;
		shadow_cfg.max_width = MAX_WIDTH_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer_sample(directed_rows[i].pins, directed_rows[i].stamp,
				directed_rows[i].typed, directed_rows[i].report);
		settle();

		// shared bit on all channels, crossed clamps
		apply_settings(3'd5, 3'd5, 3'd5, 3'd5, 16'd3000, 16'd500, 1'b1);
		run_pulses(PHASE_ITEMS);
		settle();

		apply_settings(3'd7, 3'd6, 3'd5, 3'd4, 16'd0, 16'hFFFF, 1'b0);
		run_pulses(PHASE_ITEMS);
		settle();

		apply_settings(bit_sel_t'($urandom), bit_sel_t'($urandom), bit_sel_t'($urandom),
			bit_sel_t'($urandom), 16'hFFFF, 16'd0, 1'b1);
		run_pulses(PHASE_ITEMS);
		settle();

		apply_settings(bit_sel_t'($urandom), bit_sel_t'($urandom), bit_sel_t'($urandom),
			bit_sel_t'($urandom), WIDTH_W'($urandom_range(500, 1200)),
			WIDTH_W'($urandom_range(1500, 2500)), 1'b0);
		run_pulses(PHASE_ITEMS);
		settle();

		if (mismatches == 0)
			$display("rc_pulse_width_capture_tb OK");
		else
			$display("rc_pulse_width_capture_tb NOT OK");
		$finish;
	end

endmodule

[sim.f]
hdl/rpwc_pkg.sv
hdl/rpwc_cfg_regs.sv
hdl/rpwc_channel.sv
hdl/rc_pulse_width_capture.sv
hdl/rpwc_checker.sv
tb/sv/rc_pulse_width_capture_tb.sv
